/* rtl/ial_pkg.sv */
// ============================================================================
// ial_pkg: shared types and constants for the insertable array list
// Operation and status codes, field widths, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package ial_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed field widths of the stream items.
   localparam int OP_BITS     = 3;
   localparam int POS_BITS    = 5;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;
   localparam int REQ_BITS    = 40;
   localparam int RSP_BITS    = 40;

   // Operation codes carried in the op field.
   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND = 3'd0,
      OP_REMOVE = 3'd1,
      OP_INSERT = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } ial_op_type;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } ial_status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load_req;
      logic           append;
      logic           remove;
      logic           clear;
      logic           idx_load;
      logic           shift_rd;
      logic           shift_wr;
      logic           insert_wr;
      logic           read_pos;
      logic           set_rsp;
      logic           use_read;
      ial_status_type rsp_status;
   } ial_cmd_type;

   // Conditions reported by the datapath to the controller.
   typedef struct packed {
      ial_op_type op;
      logic       full;
      logic       count_zero;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       idx_at_pos;
   } ial_stat_type;

endpackage

/* rtl/ial_datapath.sv */
// ============================================================================
// ial_datapath: storage and arithmetic of the insertable array list
// Holds the latched request, the entry memory, the entry count, the shift
// index and the result register. Acts only on controller commands.
// ============================================================================
module ial_datapath #(
   parameter int DEPTH     = ial_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = ial_pkg::WORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ial_pkg::OP_BITS-1:0]     req_op,
   input  logic [ial_pkg::POS_BITS-1:0]    req_pos,
   input  logic [ial_pkg::VALUE_BITS-1:0]  req_value,
   input  ial_pkg::ial_cmd_type            cmd,
   output ial_pkg::ial_stat_type           stat,
   output logic [ial_pkg::VALUE_BITS-1:0]  rsp_value,
   output logic [ial_pkg::COUNT_BITS-1:0]  rsp_count,
   output logic [ial_pkg::STATUS_BITS-1:0] rsp_status
);
   import ial_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

   logic [OP_BITS-1:0]     op_ff;
   logic [POS_BITS-1:0]    pos_ff;
   logic [WORD_BITS-1:0]   word_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [WORD_BITS-1:0]   mem [DEPTH];
   logic [WORD_BITS-1:0]   mem_rdata_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   logic [CMPW-1:0]        pos_ext, count_ext;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [WORD_BITS-1:0]   wr_data;

   // Latch the accepted request; the word keeps its low bits only.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         pos_ff  <= req_pos;
         word_ff <= WORD_BITS'(req_value);
      end
   end

   // Entry count update.
   always_comb begin
      count_in = count_ff;
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append || cmd.insert_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.remove && (count_ff != '0)) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Shift index walks down from the count to the insert position.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load) begin
         idx_in = count_ff;
      end else if (cmd.shift_wr) begin
         idx_in = idx_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Position and count compared at a common width.
   assign pos_ext   = CMPW'(pos_ff);
   assign count_ext = CMPW'(count_ff);

   // Memory port selection.
   always_comb begin
      wr_en   = cmd.append || cmd.shift_wr || cmd.insert_wr;
      wr_addr = AW'(count_ff);
      wr_data = word_ff;
      if (cmd.shift_wr) begin
         wr_addr = AW'(idx_ff);
         wr_data = mem_rdata_ff;
      end else if (cmd.insert_wr) begin
         wr_addr = AW'(pos_ext);
      end
      rd_en   = cmd.shift_rd || cmd.read_pos;
      rd_addr = cmd.shift_rd ? AW'(idx_ff - CW'(1)) : AW'(pos_ext);
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rdata_ff <= mem[rd_addr];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.set_rsp) begin
         rsp_value_ff  <= cmd.use_read ? VALUE_BITS'(mem_rdata_ff) : '0;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   // Conditions for the controller.
   always_comb begin
      stat.op           = ial_op_type'(op_ff);
      stat.full         = (count_ff == CW'(DEPTH));
      stat.count_zero   = (count_ff == '0);
      stat.pos_gt_count = (pos_ext > count_ext);
      stat.pos_ge_count = (pos_ext >= count_ext);
      stat.idx_at_pos   = (CMPW'(idx_ff) == pos_ext);
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = COUNT_BITS'(count_ff);
   assign rsp_status = rsp_status_ff;

endmodule

/* rtl/ial_controller.sv */
// ============================================================================
// ial_controller: sequencing state machine of the insertable array list
// Accepts one item, decodes the operation, steps the datapath through the
// shift loop or the memory read, and holds the result until it is taken.
// ============================================================================
module ial_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ial_pkg::ial_stat_type stat,
   output ial_pkg::ial_cmd_type  cmd
);
   import ial_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_EXEC     = 6'b000010,
      S_SHIFT_RD = 6'b000100,
      S_SHIFT_WR = 6'b001000,
      S_READ     = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_rsp    = 1'b1;
            cmd.rsp_status = ST_OK;
            state_in       = S_RESP;
            unique case (stat.op)
               OP_APPEND: begin
                  if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  cmd.remove = !stat.count_zero;
               end
               OP_INSERT: begin
                  // Range is checked before fullness.
                  if (stat.pos_gt_count) begin
                     cmd.rsp_status = ST_RANGE;
                  end else if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.set_rsp  = 1'b0;
                     cmd.idx_load = 1'b1;
                     state_in     = S_SHIFT_RD;
                  end
               end
               OP_READ: begin
                  if (stat.pos_ge_count) begin
                     cmd.rsp_status = ST_RANGE;
                  end else begin
                     cmd.set_rsp  = 1'b0;
                     cmd.read_pos = 1'b1;
                     state_in     = S_READ;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  cmd.rsp_status = ST_OK;
               end
            endcase
         end
         S_SHIFT_RD: begin
            // Once the hole reaches the position, drop the new word in.
            if (stat.idx_at_pos) begin
               cmd.insert_wr  = 1'b1;
               cmd.set_rsp    = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_RESP;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_READ: begin
            cmd.set_rsp    = 1'b1;
            cmd.use_read   = 1'b1;
            cmd.rsp_status = ST_OK;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

/* rtl/insertable_array_list.sv */
// ============================================================================
// insertable_array_list: fixed-depth ordered list of words
// Stream-in operations (append, remove last, insert, read, clear), one
// result item per operation with the word read, the count and a status.
// ============================================================================
// The block works on one item at a time. Append, remove, clear, unknown
// operations and any rejected operation pass from acceptance through the
// execute state to the result; a read adds a registered memory read. An
// insert moves each entry above the position up through the entry memory,
// whose read is registered, with one read step and one write step per entry.
// No clearing pass follows reset; entries are only read after they were
// written.
module insertable_array_list #(
   parameter int DEPTH     = ial_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = ial_pkg::WORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata fields from bit 0: op[3], position[5], value[32]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ial_pkg::REQ_BITS-1:0] req_tdata,
   // rsp_tdata fields from bit 0: read_value[32], count[5], status[2], zero pad[1]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ial_pkg::RSP_BITS-1:0] rsp_tdata
);
   import ial_pkg::*;

   ial_cmd_type              cmd;
   ial_stat_type             stat;
   logic [VALUE_BITS-1:0]    rsp_value;
   logic [COUNT_BITS-1:0]    rsp_count;
   logic [STATUS_BITS-1:0]   rsp_status;

   // Sequencing.
   ial_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and result.
   ial_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tdata[OP_BITS-1:0]),
      .req_pos    (req_tdata[OP_BITS+POS_BITS-1:OP_BITS]),
      .req_value  (req_tdata[OP_BITS+POS_BITS+VALUE_BITS-1:OP_BITS+POS_BITS]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

   // Pack the result item.
   assign rsp_tdata = {1'b0, rsp_status, rsp_count, rsp_value};

endmodule
